@@ src/tiny_cpu_instruction_execute_assert.svh @@
// ----------------------------------------------------------------------------
// tiny cpu instruction execute: assertion macros
// shared concurrent assertion forms, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TINY_CPU_INSTRUCTION_EXECUTE_ASSERT_SVH
`define TINY_CPU_INSTRUCTION_EXECUTE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TCIE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCIE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tcie_pkg.sv @@
// ----------------------------------------------------------------------------
// tcie_pkg
// shared types and constants of the tiny cpu instruction execute block
// ----------------------------------------------------------------------------
package tcie_pkg;

    localparam int DATA_DEPTH_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // instruction field positions
    localparam int OP_LSB  = 17;
    localparam int D_LSB   = 14;
    localparam int S_LSB   = 11;
    localparam int T_LSB   = 8;
    localparam int FIELD_W = 3;
    localparam int NIB_W   = 4;

    // set-register target that selects the pc
    localparam logic [3:0] TARGET_PC = 4'd8;

    typedef enum logic [1:0] {
        ACT_EXEC    = 2'd0,
        ACT_SET     = 2'd1,
        ACT_PRELOAD = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        K_EXEC,
        K_SET_REG,
        K_SET_PC,
        K_PRELOAD,
        K_NOP
    } kind_t;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_ADDI  = 3'd1,
        OP_MUL   = 3'd2,
        OP_INV   = 3'd3,
        OP_BR    = 3'd4,
        OP_LOAD  = 3'd5,
        OP_STORE = 3'd6,
        OP_HALT  = 3'd7
    } op_t;

    // branch types, carried in the d field
    localparam logic [2:0] BR_EQ = 3'd0;
    localparam logic [2:0] BR_NE = 3'd1;
    localparam logic [2:0] BR_LT = 3'd2;

    typedef struct packed {
        kind_t      kind;
        op_t        op;
        logic [2:0] d;
        logic [2:0] s;
        logic [2:0] t;
        logic [7:0] imm;
        logic [7:0] value;
        logic [7:0] addr;
    } dec_t;

    typedef struct packed {
        logic       illegal;
        logic       halted;
        logic [7:0] mem_value;
        logic [7:0] mem_address;
        logic       mem_written;
        logic [7:0] reg_value;
        logic [2:0] reg_index;
        logic       reg_written;
        logic [7:0] next_pc;
    } res_t;

endpackage

@@ src/tcie_ram.sv @@
// ----------------------------------------------------------------------------
// tcie_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tcie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tcie_front.sv @@
// ----------------------------------------------------------------------------
// tcie_front
// input handshake and classification of incoming words
// ----------------------------------------------------------------------------
module tcie_front
    import tcie_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  action,
    input  logic [19:0] instruction,
    input  logic [3:0]  target_reg,
    input  logic [7:0]  byte_address,
    input  logic [7:0]  byte_value,
    input  logic        q_full,
    output logic        q_push,
    output dec_t        q_data
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_data       = '0;
        q_data.op    = op_t'(instruction[OP_LSB +: FIELD_W]);
        q_data.d     = instruction[D_LSB +: FIELD_W];
        q_data.s     = instruction[S_LSB +: FIELD_W];
        q_data.t     = instruction[T_LSB +: FIELD_W];
        q_data.imm   = instruction[7:0];
        q_data.value = byte_value;
        q_data.addr  = byte_address;
        q_data.kind  = K_NOP;
        case (action)
            ACT_EXEC: begin
                q_data.kind = K_EXEC;
            end
            ACT_SET: begin
                if (target_reg < TARGET_PC) begin
                    q_data.kind = K_SET_REG;
                    q_data.d    = target_reg[2:0];
                end else if (target_reg == TARGET_PC) begin
                    q_data.kind = K_SET_PC;
                end
            end
            ACT_PRELOAD: begin
                q_data.kind = K_PRELOAD;
            end
            default: begin
                q_data.kind = K_NOP;
            end
        endcase
    end

endmodule

@@ src/tcie_queue.sv @@
// ----------------------------------------------------------------------------
// tcie_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module tcie_queue
    import tcie_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  dec_t push_data,
    input  logic pop,
    output logic full,
    output logic empty,
    output dec_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dec_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/tcie_back.sv @@
// ----------------------------------------------------------------------------
// tcie_back
// execution of classified words: register file, pc, halt, data store
// ----------------------------------------------------------------------------
module tcie_back
    import tcie_pkg::*;
#(
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic head_valid,
    input  dec_t head,
    output logic pop,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    localparam int AW = $clog2(DATA_DEPTH);

    logic [7:0]            rf_reg [8];
    logic [7:0]            pc_reg, pc_next;
    logic                  halt_reg, halt_next;
    logic [DATA_DEPTH-1:0] vld_reg;

    // output stage
    logic                  w_valid_reg;
    res_t                  w_res_reg;
    logic                  w_load_reg;
    logic                  w_hit_reg;

    // load write-back, in the cycle after the read is issued
    logic                  wb_pend_reg;
    logic [2:0]            wb_idx_reg;

    logic [7:0]            ram_rdata, load_data;
    logic [7:0]            vs, vt;
    logic                  fire;
    res_t                  res;
    logic                  rf_we;
    logic [7:0]            rf_wdata;
    logic                  mem_we;
    logic [7:0]            mem_addr, mem_wdata;
    logic                  ld, ld_hit;
    logic                  adv;
    logic                  take;

    assign fire      = head_valid && (!w_valid_reg || m_ready);
    assign pop       = fire;
    assign load_data = w_hit_reg ? ram_rdata : 8'd0;

    // operand read with bypass of a pending load
    assign vs = (wb_pend_reg && wb_idx_reg == head.s) ? load_data : rf_reg[head.s];
    assign vt = (wb_pend_reg && wb_idx_reg == head.t) ? load_data : rf_reg[head.t];

    always_comb begin
        res         = '0;
        rf_we       = 1'b0;
        rf_wdata    = '0;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        mem_we      = 1'b0;
        mem_addr    = head.addr;
        mem_wdata   = head.value;
        ld          = 1'b0;
        ld_hit      = 1'b0;
        adv         = 1'b0;
        take        = 1'b0;
        case (head.kind)
            K_EXEC: begin
                if (!halt_reg) begin
                    adv = 1'b1;
                    case (head.op)
                        OP_ADD: begin
                            rf_we    = 1'b1;
                            rf_wdata = vs + vt;
                        end
                        OP_ADDI: begin
                            rf_we    = 1'b1;
                            rf_wdata = vs + head.imm;
                        end
                        OP_MUL: begin
                            rf_we    = 1'b1;
                            rf_wdata = {4'd0, vs[7:NIB_W]} * {4'd0, vs[NIB_W-1:0]};
                        end
                        OP_INV: begin
                            rf_we    = 1'b1;
                            rf_wdata = ~vs;
                        end
                        OP_BR: begin
                            if (head.d == BR_EQ) begin
                                take = (vs == vt);
                            end else if (head.d == BR_NE) begin
                                take = (vs != vt);
                            end else if (head.d == BR_LT) begin
                                take = (vs < vt);
                            end else begin
                                res.illegal = 1'b1;
                                adv         = 1'b0;
                            end
                            if (take) begin
                                pc_next = head.imm;
                                adv     = 1'b0;
                            end
                        end
                        OP_LOAD: begin
                            ld              = 1'b1;
                            ld_hit          = ({1'b0, vt} < 9'(DATA_DEPTH))
                                              && vld_reg[vt[AW-1:0]];
                            res.reg_written = 1'b1;
                            res.reg_index   = head.d;
                        end
                        OP_STORE: begin
                            if ({1'b0, vt} < 9'(DATA_DEPTH)) begin
                                mem_we          = 1'b1;
                                mem_addr        = vt;
                                mem_wdata       = vs;
                                res.mem_written = 1'b1;
                                res.mem_address = vt;
                                res.mem_value   = vs;
                            end
                        end
                        OP_HALT: begin
                            halt_next = 1'b1;
                        end
                        default: begin
                            adv = 1'b0;
                        end
                    endcase
                    if (adv) begin
                        pc_next = pc_reg + 8'd1;
                    end
                    if (rf_we) begin
                        res.reg_written = 1'b1;
                        res.reg_index   = head.d;
                        res.reg_value   = rf_wdata;
                    end
                end
            end
            K_SET_REG: begin
                rf_we           = 1'b1;
                rf_wdata        = head.value;
                res.reg_written = 1'b1;
                res.reg_index   = head.d;
                res.reg_value   = head.value;
            end
            K_SET_PC: begin
                pc_next = head.value;
            end
            K_PRELOAD: begin
                mem_we = ({1'b0, head.addr} < 9'(DATA_DEPTH));
            end
            default: begin
                rf_we = 1'b0;
            end
        endcase
        res.next_pc = pc_next;
        res.halted  = halt_next;
    end

    tcie_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (fire && mem_we),
        .waddr (mem_addr[AW-1:0]),
        .wdata (mem_wdata),
        .re    (fire && ld),
        .raddr (vt[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_reg      <= '{default: '0};
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            vld_reg     <= '0;
            w_valid_reg <= 1'b0;
            wb_pend_reg <= 1'b0;
        end else begin
            // a register write from the word at the head is younger and wins
            if (wb_pend_reg) begin
                rf_reg[wb_idx_reg] <= load_data;
            end
            if (fire && rf_we) begin
                rf_reg[head.d] <= rf_wdata;
            end
            wb_pend_reg <= fire && ld;
            if (fire) begin
                pc_reg      <= pc_next;
                halt_reg    <= halt_next;
                w_valid_reg <= 1'b1;
                if (mem_we) begin
                    vld_reg[mem_addr[AW-1:0]] <= 1'b1;
                end
            end else if (m_ready) begin
                w_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            w_res_reg  <= res;
            w_load_reg <= ld;
            w_hit_reg  <= ld_hit;
            wb_idx_reg <= head.d;
        end
    end

    always_comb begin
        m_res = w_res_reg;
        if (w_load_reg) begin
            m_res.reg_value = load_data;
        end
    end

    assign m_valid = w_valid_reg;

endmodule

@@ src/tiny_cpu_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_execute
// eight-register cpu that executes one instruction or debug word per word
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one word per instruction, register/pc set or store preload;
//     s_tuser carries the action, s_tdata the instruction and debug fields
//   m_ channel: one result word per input word, in order, carrying the
//     pc after the word, register and store write reports, halt and illegal
//   path: accepted word, queue slot, output register driving m_tvalid
//   throughput: one word per cycle while results are taken, loads included;
//     a load result comes from the registered store read and is bypassed to
//     the next word's operands while it is written back to the register file
//   front classifies words into a two-entry queue, back executes them;
//     the back stalls only when its output register is full and not taken
//   m_tready low: the result holds, the queue fills, then s_tready drops
//   reset: registers, pc and halt clear; the data store reads as zero
//     through per-entry valid bits, so no clearing pass is needed
// ----------------------------------------------------------------------------
`include "tiny_cpu_instruction_execute_assert.svh"

module tiny_cpu_instruction_execute
    import tcie_pkg::*;
#(
    parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // instruction[19:0], target_reg[23:20], byte_address[31:24], byte_value[39:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_pc[7:0], reg_written[8], reg_index[11:9], reg_value[19:12],
    // mem_written[20], mem_address[28:21], mem_value[36:29], halted[37],
    // illegal[38], zero[39]
    output logic [M_TDATA_W-1:0] m_tdata
);

    dec_t q_in, q_head;
    logic q_push, q_full, q_empty;
    logic back_pop;
    res_t m_res;

    // front: handshake and classification
    tcie_front u_front (
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .action       (s_tuser),
        .instruction  (s_tdata[19:0]),
        .target_reg   (s_tdata[23:20]),
        .byte_address (s_tdata[31:24]),
        .byte_value   (s_tdata[39:32]),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    // queue decouples the input side from execution stalls
    tcie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (back_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back: executes the head word into the output register
    tcie_back #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_empty),
        .head       (q_head),
        .pop        (back_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (m_res)
    );

    // result packing, lowest field first
    assign m_tdata = {1'b0, m_res};

    // no word leaves the queue while the held result is still waiting
    `TCIE_ASSERT_NOW(a_no_pop_on_stall, aclk, aresetn, m_tvalid && !m_tready, !back_pop, "word executed while result stalled")

    // an illegal branch writes neither a register nor the store
    `TCIE_ASSERT_NOW(a_illegal_no_effect, aclk, aresetn, m_tvalid && m_res.illegal, !m_res.reg_written && !m_res.mem_written, "illegal word reported a write")

    // a taken result with nothing behind it empties the output register
    `TCIE_ASSERT_NEXT(a_out_drains, aclk, aresetn, m_tvalid && m_tready && !back_pop, !m_tvalid, "result repeated after acceptance")

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for tiny_cpu_instruction_execute
// drives instruction and debug words on the s_ stream, predicts every result
// word with a cycle-free model of the cpu state, and compares each m_ word
// field by field; both sides idle at random, with a long result hold-off and
// a sender pause; the halt instruction is exercised last since reset is single
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcie_pkg::*;

    // action code that the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    // tail after the last expected result
    localparam int DRAIN_CYCLES = 8;

    // one input word as the bench sees it
    typedef struct packed {
        logic [1:0]  action;
        logic [19:0] instr;
        logic [3:0]  target;
        logic [7:0]  baddr;
        logic [7:0]  bval;
    } cpu_word_t;

    // dut connections, all inputs known from time zero
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // architectural state of the prediction
    logic [7:0] arch_regs [8];
    logic [7:0] arch_pc;
    logic       arch_halted;
    logic [7:0] arch_mem [DATA_DEPTH_DEF];

    // results predicted at input acceptance and not yet seen on m_
    res_t pending_results [$];

    // idling bounds, changed by the tests; sink_hold asks for one long hold-off
    int src_idle_max  = 0;
    int sink_idle_max = 0;
    int sink_hold     = 0;

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int loads_done      = 0;
    int stores_done     = 0;
    int branches_taken  = 0;
    int illegal_seen    = 0;
    int idle_cycles     = 0;

    res_t      mon_got;
    res_t      mon_want;
    cpu_word_t mon_word;

    tiny_cpu_instruction_execute u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // instruction[19:0], target_reg[23:20], byte_address[31:24], byte_value[39:32]
        .s_tdata  (s_tdata),
        // action[1:0]
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // next_pc[7:0], reg_written[8], reg_index[11:9], reg_value[19:12],
        // mem_written[20], mem_address[28:21], mem_value[36:29], halted[37],
        // illegal[38], zero[39]
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // prediction: apply one accepted word to the architectural state
    // ------------------------------------------------------------------------
    task automatic execute_word(input cpu_word_t w, output res_t r);
        op_t        op;
        logic [2:0] rd;
        logic [2:0] rs;
        logic [2:0] rt;
        logic [7:0] imm;
        logic [7:0] vs;
        logic [7:0] vt;
        logic       take;
        logic       advance;
        r   = '0;
        op  = op_t'(w.instr[OP_LSB +: FIELD_W]);
        rd  = w.instr[D_LSB +: FIELD_W];
        rs  = w.instr[S_LSB +: FIELD_W];
        rt  = w.instr[T_LSB +: FIELD_W];
        imm = w.instr[7:0];
        vs  = arch_regs[rs];
        vt  = arch_regs[rt];
        case (w.action)
            ACT_EXEC: begin
                // a halted cpu ignores every instruction
                if (!arch_halted) begin
                    advance = 1'b1;
                    case (op)
                        OP_ADD: begin
                            r.reg_written = 1'b1;
                            r.reg_index   = rd;
                            r.reg_value   = vs + vt;
                        end
                        OP_ADDI: begin
                            r.reg_written = 1'b1;
                            r.reg_index   = rd;
                            r.reg_value   = vs + imm;
                        end
                        OP_MUL: begin
                            // upper nibble times lower nibble of the source
                            r.reg_written = 1'b1;
                            r.reg_index   = rd;
                            r.reg_value   = {4'd0, vs[7:4]} * {4'd0, vs[3:0]};
                        end
                        OP_INV: begin
                            r.reg_written = 1'b1;
                            r.reg_index   = rd;
                            r.reg_value   = ~vs;
                        end
                        OP_BR: begin
                            // branch type sits in the d field, compare is unsigned
                            take = 1'b0;
                            case (rd)
                                BR_EQ:   take = (vs == vt);
                                BR_NE:   take = (vs != vt);
                                BR_LT:   take = (vs < vt);
                                default: begin
                                    // undefined type leaves even the pc alone
                                    r.illegal = 1'b1;
                                    advance   = 1'b0;
                                    illegal_seen++;
                                end
                            endcase
                            if (take) begin
                                arch_pc = imm;
                                advance = 1'b0;
                                branches_taken++;
                            end
                        end
                        OP_LOAD: begin
                            r.reg_written = 1'b1;
                            r.reg_index   = rd;
                            r.reg_value   = (int'(vt) < DATA_DEPTH_DEF) ? arch_mem[vt] : 8'd0;
                            loads_done++;
                        end
                        OP_STORE: begin
                            // addresses past the store are dropped silently
                            if (int'(vt) < DATA_DEPTH_DEF) begin
                                arch_mem[vt]  = vs;
                                r.mem_written = 1'b1;
                                r.mem_address = vt;
                                r.mem_value   = vs;
                                stores_done++;
                            end
                        end
                        default: begin
                            arch_halted = 1'b1;
                        end
                    endcase
                    if (r.reg_written)
                        arch_regs[rd] = r.reg_value;
                    if (advance)
                        arch_pc = arch_pc + 8'd1;
                end
            end
            ACT_SET: begin
                // debug set works while halted; targets past the pc do nothing
                if (w.target < TARGET_PC) begin
                    arch_regs[w.target[2:0]] = w.bval;
                    r.reg_written = 1'b1;
                    r.reg_index   = w.target[2:0];
                    r.reg_value   = w.bval;
                end else if (w.target == TARGET_PC) begin
                    arch_pc = w.bval;
                end
            end
            ACT_PRELOAD: begin
                // preload never reports a store write
                if (int'(w.baddr) < DATA_DEPTH_DEF)
                    arch_mem[w.baddr] = w.bval;
            end
            default: begin
            end
        endcase
        r.next_pc = arch_pc;
        r.halted  = arch_halted;
    endtask

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 50)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                      results_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // monitor: check result words first, then predict the accepted input word;
    // with the queue and the output register between input and result, a result
    // never belongs to the word accepted on the same edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                mon_got = res_t'(m_tdata[$bits(res_t)-1:0]);
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with no expectation waiting");
                end else begin
                    mon_want = pending_results.pop_front();
                    check_field("next_pc",     mon_got.next_pc,     mon_want.next_pc);
                    check_field("reg_written", mon_got.reg_written, mon_want.reg_written);
                    check_field("reg_index",   mon_got.reg_index,   mon_want.reg_index);
                    check_field("reg_value",   mon_got.reg_value,   mon_want.reg_value);
                    check_field("mem_written", mon_got.mem_written, mon_want.mem_written);
                    check_field("mem_address", mon_got.mem_address, mon_want.mem_address);
                    check_field("mem_value",   mon_got.mem_value,   mon_want.mem_value);
                    check_field("halted",      mon_got.halted,      mon_want.halted);
                    check_field("illegal",     mon_got.illegal,     mon_want.illegal);
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) begin
                mon_word = {s_tuser, s_tdata[19:0], s_tdata[23:20],
                            s_tdata[31:24], s_tdata[39:32]};
                execute_word(mon_word, mon_want);
                pending_results.push_back(mon_want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no word moving for too long ends the run
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("tiny_cpu_instruction_execute regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall before each result, or one long hold-off
    // ------------------------------------------------------------------------
    initial begin : sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall     = (sink_hold > 0) ? sink_hold : $urandom_range(0, sink_idle_max);
            sink_hold = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // offer one word after a random gap; valid stays high when the gap is zero
    task automatic send_word(input cpu_word_t w);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.bval, w.baddr, w.target, w.instr};
        s_tuser  <= w.action;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // stop offering and wait until every predicted result has come back;
    // the first edge lets the monitor record the last accepted word
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic cpu_word_t exec_word(input op_t op, input logic [2:0] d,
                                            input logic [2:0] s, input logic [2:0] t,
                                            input logic [7:0] imm);
        cpu_word_t w;
        w        = '0;
        w.action = ACT_EXEC;
        w.instr  = {op, d, s, t, imm};
        return w;
    endfunction

    function automatic cpu_word_t set_word(input logic [3:0] target, input logic [7:0] value);
        cpu_word_t w;
        w        = '0;
        w.action = ACT_SET;
        w.target = target;
        w.bval   = value;
        return w;
    endfunction

    function automatic cpu_word_t preload_word(input logic [7:0] addr, input logic [7:0] value);
        cpu_word_t w;
        w        = '0;
        w.action = ACT_PRELOAD;
        w.baddr  = addr;
        w.bval   = value;
        return w;
    endfunction

    // mostly instructions, some debug words and ignored actions;
    // every field is random, including those the action does not use
    function automatic cpu_word_t random_word(input bit allow_halt);
        cpu_word_t w;
        int        pick;
        w.instr  = 20'($urandom);
        w.target = 4'($urandom_range(0, 15));
        w.baddr  = 8'($urandom_range(0, 255));
        w.bval   = 8'($urandom_range(0, 255));
        pick     = $urandom_range(0, 99);
        if (pick < 70) begin
            w.action = ACT_EXEC;
            // halting early would mute the rest of the run
            if (!allow_halt && w.instr[OP_LSB +: FIELD_W] == OP_HALT)
                w.instr[OP_LSB +: FIELD_W] = 3'($urandom_range(0, 6));
            // favor the defined branch types, leave some illegal ones
            if (w.instr[OP_LSB +: FIELD_W] == OP_BR && $urandom_range(0, 3) != 0)
                w.instr[D_LSB +: FIELD_W] = 3'($urandom_range(0, 2));
        end else if (pick < 85) begin
            w.action = ACT_SET;
            if ($urandom_range(0, 9) != 0)
                w.target = 4'($urandom_range(0, 8));
        end else if (pick < 95) begin
            w.action = ACT_PRELOAD;
        end else begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    // pick one of the idling mixes, including none at all
    task automatic pick_idling();
        case ($urandom_range(0, 3))
            0: begin src_idle_max = 0;  sink_idle_max = 0;  end
            1: begin src_idle_max = 10; sink_idle_max = 0;  end
            2: begin src_idle_max = 0;  sink_idle_max = 10; end
            default: begin
                src_idle_max  = $urandom_range(0, 10);
                sink_idle_max = $urandom_range(0, 10);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // extremes, every operation but halt and the corner cases, back to back
    task automatic test_directed_cases();
        src_idle_max  = 0;
        sink_idle_max = 0;
        send_word(set_word(4'd1, 8'hFF));
        send_word(set_word(4'd2, 8'h01));
        send_word(exec_word(OP_ADD, 3'd3, 3'd1, 3'd2, 8'h00));      // 255 + 1 wraps to 0
        send_word(exec_word(OP_ADDI, 3'd4, 3'd1, 3'd0, 8'hFF));     // 255 + 255
        send_word(exec_word(OP_MUL, 3'd5, 3'd1, 3'd0, 8'h00));      // 15 * 15
        send_word(exec_word(OP_INV, 3'd6, 3'd2, 3'd0, 8'h00));
        send_word(preload_word(8'hFF, 8'hA5));
        send_word(set_word(4'd7, 8'hFF));
        send_word(exec_word(OP_LOAD, 3'd0, 3'd0, 3'd7, 8'h00));     // top of the store
        send_word(exec_word(OP_STORE, 3'd0, 3'd1, 3'd2, 8'h00));
        send_word(exec_word(OP_LOAD, 3'd3, 3'd0, 3'd2, 8'h00));     // load right after store
        send_word(exec_word(OP_LOAD, 3'd5, 3'd0, 3'd0, 8'h00));     // load-use, never written
        send_word(exec_word(OP_BR, BR_EQ, 3'd1, 3'd7, 8'h40));      // taken
        send_word(exec_word(OP_BR, BR_NE, 3'd1, 3'd7, 8'h00));      // not taken
        send_word(exec_word(OP_BR, BR_LT, 3'd2, 3'd1, 8'hFF));      // taken to 255
        send_word(exec_word(OP_BR, BR_LT, 3'd1, 3'd2, 8'h00));      // unsigned, pc wraps
        send_word(exec_word(OP_BR, 3'd3, 3'd1, 3'd2, 8'h11));       // illegal types
        send_word(exec_word(OP_BR, 3'd7, 3'd7, 3'd7, 8'hFF));
        send_word(set_word(TARGET_PC, 8'h10));
        send_word(set_word(4'd9, 8'h33));                           // targets past the pc
        send_word(set_word(4'd15, 8'hFF));
        send_word({ACT_UNUSED, 20'hFFFFF, 4'hF, 8'hFF, 8'hFF});     // ignored action
        send_word(preload_word(8'h00, 8'h00));
        send_word(set_word(4'd0, 8'h00));
        wait_results_done();
    endtask

    // preload, point a register at it, load, modify, store back and reload,
    // so dependent words run through the load bypass
    task automatic test_load_store_chains(input int count);
        logic [7:0] addr;
        logic [2:0] ra;
        logic [2:0] rd;
        logic [2:0] rm;
        for (int i = 0; i < count; i++) begin
            if (i % 8 == 0)
                pick_idling();
            addr = 8'($urandom_range(0, 255));
            ra   = 3'($urandom_range(0, 7));
            rd   = 3'($urandom_range(0, 7));
            rm   = 3'($urandom_range(0, 7));
            send_word(preload_word(addr, 8'($urandom_range(0, 255))));
            send_word(set_word({1'b0, ra}, addr));
            send_word(exec_word(OP_LOAD, rd, 3'($urandom_range(0, 7)), ra,
                                8'($urandom_range(0, 255))));
            send_word(exec_word(op_t'($urandom_range(0, 3)), rm, rd, rd,
                                8'($urandom_range(0, 255))));
            send_word(exec_word(OP_STORE, 3'($urandom_range(0, 7)), rm, ra, 8'h00));
            send_word(exec_word(OP_LOAD, rd, 3'd0, ra, 8'h00));
        end
        wait_results_done();
    endtask

    // bulk random words, idling mix changed every hundred words
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0)
                pick_idling();
            send_word(random_word(1'b0));
        end
        wait_results_done();
    endtask

    // long result hold-off while words keep coming, so the queue fills
    // and s_tready drops
    task automatic test_input_backpressure();
        src_idle_max  = 0;
        sink_idle_max = 0;
        sink_hold     = 300;
        for (int i = 0; i < 40; i++)
            send_word(random_word(1'b0));
        wait_results_done();
    endtask

    // sender stops mid-stream until every result is back, then resumes
    task automatic test_sender_pause();
        src_idle_max  = 3;
        sink_idle_max = 6;
        for (int i = 0; i < 30; i++)
            send_word(random_word(1'b0));
        wait_results_done();
        for (int i = 0; i < 30; i++)
            send_word(random_word(1'b0));
        wait_results_done();
    endtask

    // halt last: the cpu stays halted until reset, which comes only once
    task automatic test_halt_and_after();
        pick_idling();
        send_word(exec_word(OP_ADDI, 3'd1, 3'd1, 3'd0, 8'h01));
        send_word({ACT_EXEC, 20'hFFFFF, 4'h0, 8'h00, 8'h00});       // halt, all bits set
        send_word(exec_word(OP_ADD, 3'd2, 3'd1, 3'd1, 8'h00));      // ignored
        send_word(set_word(4'd3, 8'h5A));                           // debug still works
        send_word(preload_word(8'h20, 8'h77));
        send_word(set_word(TARGET_PC, 8'hFE));
        send_word(exec_word(OP_HALT, 3'd0, 3'd0, 3'd0, 8'h00));
        for (int i = 0; i < 40; i++)
            send_word(random_word(1'b1));
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 8; i++)
            arch_regs[i] = 8'd0;
        for (int i = 0; i < DATA_DEPTH_DEF; i++)
            arch_mem[i] = 8'd0;
        arch_pc     = 8'd0;
        arch_halted = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_load_store_chains(30);
        test_random_mix(700);
        test_input_backpressure();
        test_sender_pause();
        test_halt_and_after();

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        $display("run covered %0d words, %0d results checked, %0d loads, %0d stores",
                 words_sent, results_checked, loads_done, stores_done);
        $display("with %0d taken branches, %0d illegal branches, halt at the end, %0d errors",
                 branches_taken, illegal_seen, errors);
        if (errors == 0)
            $display("tiny_cpu_instruction_execute regression: pass");
        else
            $display("tiny_cpu_instruction_execute regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/tcie_pkg.sv
src/tcie_ram.sv
src/tcie_front.sv
src/tcie_queue.sv
src/tcie_back.sv
src/tiny_cpu_instruction_execute.sv
bench/tb_top.sv
